/* hdl/minimum_spanning_tree_dense_core_defines.svh */
// ----------------------------------------------------------------------------
// Dense MST core assertion macros
// Shared property wrappers for the checker.
// ----------------------------------------------------------------------------
`ifndef MINIMUM_SPANNING_TREE_DENSE_CORE_DEFINES_SVH
`define MINIMUM_SPANNING_TREE_DENSE_CORE_DEFINES_SVH

// implication checked at every rising edge outside reset
`define MST_ASSERT(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// same, with the consequent checked in the cycle after the antecedent
`define MST_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/mst_pkg.sv */
// ----------------------------------------------------------------------------
// Dense MST package
// Shared constants, codes and state type.
// ----------------------------------------------------------------------------
`default_nettype none
package mst_pkg;
    localparam int MAX_NODES_DEF   = 64;
    localparam int WEIGHT_BITS_DEF = 16;
    localparam int NODE_FIELD_BITS = 7;
    localparam int TOTAL_BITS      = 22;
    localparam int OP_BITS         = 2;
    localparam int STATUS_BITS     = 2;

    localparam logic [OP_BITS-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_BITS-1:0] STATUS_EDGE   = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_DISC   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_SINGLE = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRIME,
        ST_RUN,
        ST_EMIT
    } state_t;
endpackage
`default_nettype wire

/* hdl/mst_cell.sv */
// ----------------------------------------------------------------------------
// Dense MST cell
// One node slot of the rotating chain: id, best cost, nearest tree node.
// ----------------------------------------------------------------------------
`default_nettype none
module mst_cell #(
    parameter int ID_BITS = 7,
    parameter int W       = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               init_en,
    input  wire logic               shift_en,
    input  wire logic [ID_BITS-1:0] init_id,
    input  wire logic [ID_BITS-1:0] d_id,
    input  wire logic [W-1:0]       d_cost,
    input  wire logic [ID_BITS-1:0] d_near,
    input  wire logic               d_in,
    output logic      [ID_BITS-1:0] q_id,
    output logic      [W-1:0]       q_cost,
    output logic      [ID_BITS-1:0] q_near,
    output logic                    q_in
);
    logic [ID_BITS-1:0] id_reg, near_reg;
    logic [W-1:0]       cost_reg;
    logic               in_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= 1'b0;
        end
        else if (init_en)
        begin
            in_reg <= 1'b0;
        end
        else if (shift_en)
        begin
            in_reg <= d_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (init_en)
        begin
            id_reg   <= init_id;
            cost_reg <= '1;
            near_reg <= ID_BITS'(1);
        end
        else if (shift_en)
        begin
            id_reg   <= d_id;
            cost_reg <= d_cost;
            near_reg <= d_near;
        end
    end

    assign q_id   = id_reg;
    assign q_cost = cost_reg;
    assign q_near = near_reg;
    assign q_in   = in_reg;
endmodule
`default_nettype wire

/* hdl/mst_store.sv */
// ----------------------------------------------------------------------------
// Dense MST weight store
// Triangular edge-weight memory with a one-entry-per-cycle clear sweep.
// ----------------------------------------------------------------------------
`default_nettype none
module mst_store #(
    parameter int MAX_NODES = 64,
    parameter int W         = 16,
    parameter int ID_BITS   = 7
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               clr_start,
    output logic                    busy,
    input  wire logic               wr_en,
    input  wire logic [ID_BITS-1:0] wr_a,
    input  wire logic [ID_BITS-1:0] wr_b,
    input  wire logic [W-1:0]       wr_data,
    input  wire logic [ID_BITS-1:0] rd_a,
    input  wire logic [ID_BITS-1:0] rd_b,
    output logic      [W-1:0]       rd_data
);
    localparam int DEPTH     = MAX_NODES * (MAX_NODES - 1) / 2;
    localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PROD_BITS = 2 * ID_BITS;

    logic [W-1:0]         mem [DEPTH];
    logic [ADDR_BITS-1:0] clr_addr_reg;
    logic                 busy_reg;

    // (hi-1)(hi-2)/2 + lo-1
    function automatic logic [ADDR_BITS-1:0] pair_idx(
        input logic [ID_BITS-1:0] a,
        input logic [ID_BITS-1:0] b
    );
        logic [ID_BITS-1:0]   hi, lo;
        logic [PROD_BITS-1:0] prod;
        hi   = (a > b) ? a : b;
        lo   = (a > b) ? b : a;
        prod = PROD_BITS'(hi - ID_BITS'(1)) * PROD_BITS'(hi - ID_BITS'(2));
        return ADDR_BITS'((prod >> 1) + PROD_BITS'(lo - ID_BITS'(1)));
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_start)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == ADDR_BITS'(DEPTH - 1))
            begin
                busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + ADDR_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '1;
        end
        else if (wr_en)
        begin
            mem[pair_idx(wr_a, wr_b)] <= wr_data;
        end
        rd_data <= mem[pair_idx(rd_a, rd_b)];
    end

    assign busy = busy_reg;
endmodule
`default_nettype wire

/* hdl/minimum_spanning_tree_dense_core.sv */
// ----------------------------------------------------------------------------
// Dense Prim minimum spanning tree core
// Edge-weight store plus a rotating chain of node cells that relaxes and
// searches the frontier one node per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: s_tuser carries the operation (write edge, run, clear);
//   s_tdata carries node_a, node_b and edge_weight. One word per item.
//   Output stream m_*: one word per tree step, m_tlast on the final one,
//   m_tuser is the status (edge, disconnected, single node).
//   cfg_we/cfg_wdata write node_count while the core is idle.
// Timing:
//   Writes are taken in idle and stream back to back.
//   A clear sweeps the store at one entry per cycle over all
//   MAX_NODES*(MAX_NODES-1)/2 entries, with s_tready low until it is back in idle.
//   Reset starts the same sweep.
//   A run goes through PRIME, RUN and EMIT for each tree step: PRIME primes the
//   store read, RUN rotates the whole cell ring past the single store read
//   port, and EMIT loads the output word register. A single-node run goes
//   from IDLE straight to EMIT, with no pass over the ring.
//   Output is registered; if m_tready is low the engine holds at the finished
//   step until the word register frees up. s_tready is high only between runs.
// ----------------------------------------------------------------------------
`default_nettype none
module minimum_spanning_tree_dense_core #(
    parameter int MAX_NODES   = mst_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = mst_pkg::WEIGHT_BITS_DEF,
    localparam int IN_BITS    = 2 * mst_pkg::NODE_FIELD_BITS + WEIGHT_BITS,
    localparam int IN_W       = (IN_BITS + 7) / 8 * 8,
    localparam int OUT_BITS   = 2 * mst_pkg::NODE_FIELD_BITS + WEIGHT_BITS
                                + mst_pkg::TOTAL_BITS,
    localparam int OUT_W      = (OUT_BITS + 7) / 8 * 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [IN_W-1:0]                   s_tdata,  // node_a, node_b, edge_weight
    input  wire logic [mst_pkg::OP_BITS-1:0]       s_tuser,  // operation
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic      [OUT_W-1:0]                  m_tdata,  // tree_from, tree_to,
                                                             // chosen_weight, total_weight
    output logic      [mst_pkg::STATUS_BITS-1:0]   m_tuser,  // status
    output logic                                   m_tlast,  // last
    input  wire logic                              cfg_we,
    input  wire logic [mst_pkg::NODE_FIELD_BITS-1:0] cfg_wdata // node_count
);
    localparam int NF      = mst_pkg::NODE_FIELD_BITS;
    localparam int TB      = mst_pkg::TOTAL_BITS;
    localparam int W       = WEIGHT_BITS;
    localparam int ID_BITS = $clog2(MAX_NODES + 1);
    localparam int NC      = MAX_NODES - 1;
    localparam int NEXT    = (NC > 1) ? 1 : 0;
    localparam int CNT_B   = $clog2(NC + 1);

    // input unpack
    logic [NF-1:0] in_a, in_b;
    logic [W-1:0]  in_w;
    assign in_a = s_tdata[NF-1:0];
    assign in_b = s_tdata[2*NF-1:NF];
    assign in_w = s_tdata[2*NF+W-1:2*NF];

    logic [NF-1:0]      node_count_reg;
    logic [ID_BITS-1:0] n_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NF'(1);
        end
        else if (cfg_we)
        begin
            node_count_reg <= cfg_wdata;
        end
    end

    // node_count of 0 acts as 1, above MAX_NODES saturates
    always_comb
    begin
        if (node_count_reg == '0)
        begin
            n_eff = ID_BITS'(1);
        end
        else if (int'(node_count_reg) > MAX_NODES)
        begin
            n_eff = ID_BITS'(MAX_NODES);
        end
        else
        begin
            n_eff = ID_BITS'(node_count_reg);
        end
    end

    mst_pkg::state_t state_reg, state_next;

    logic               accept;
    logic               wr_ok;
    logic               st_busy;
    logic               clr_start;
    logic               init_en;
    logic               shift_en;
    logic               out_load;
    logic [W-1:0]       rd_data;
    logic [ID_BITS-1:0] rd_b;

    logic [ID_BITS-1:0] pick_reg, steps_reg;
    logic [CNT_B-1:0]   cnt_reg;
    logic [W-1:0]       best_val_reg;
    logic [ID_BITS-1:0] best_id_reg, best_near_reg;
    logic [TB-1:0]      total_reg;

    logic [NF-1:0]                   pend_from_reg, pend_to_reg;
    logic [W-1:0]                    pend_w_reg;
    logic [mst_pkg::STATUS_BITS-1:0] pend_status_reg;
    logic                            pend_last_reg;

    logic               m_valid_reg;
    logic [OUT_W-1:0]   m_data_reg;
    logic [mst_pkg::STATUS_BITS-1:0] m_user_reg;
    logic               m_last_reg;

    assign accept = s_tvalid && s_tready;
    assign wr_ok  = (in_a != in_b) && (in_a != '0) && (in_b != '0)
                    && (int'(in_a) <= MAX_NODES) && (int'(in_b) <= MAX_NODES);

    // cell ring
    logic [ID_BITS-1:0] c_id   [NC];
    logic [W-1:0]       c_cost [NC];
    logic [ID_BITS-1:0] c_near [NC];
    logic               c_in   [NC];

    // head cell: relax against the pick, then compete for the minimum
    logic               h_excl, h_upd, h_cand;
    logic [W-1:0]       h_cost;
    logic [ID_BITS-1:0] h_near;
    logic               h_in;

    always_comb
    begin
        h_excl = (c_id[0] == pick_reg) || c_in[0] || (c_id[0] > n_eff);
        h_upd  = !h_excl && (rd_data < c_cost[0]);
        h_cost = h_upd ? rd_data : c_cost[0];
        h_near = h_upd ? pick_reg : c_near[0];
        h_in   = c_in[0] || (c_id[0] == pick_reg);
        h_cand = !h_excl && (h_cost < best_val_reg);
    end

    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++)
        begin : g_cell
            logic [ID_BITS-1:0] d_id, d_near;
            logic [W-1:0]       d_cost;
            logic               d_in;
            if (gi == NC - 1)
            begin : g_tail
                assign d_id   = c_id[0];
                assign d_cost = h_cost;
                assign d_near = h_near;
                assign d_in   = h_in;
            end
            else
            begin : g_mid
                assign d_id   = c_id[gi+1];
                assign d_cost = c_cost[gi+1];
                assign d_near = c_near[gi+1];
                assign d_in   = c_in[gi+1];
            end
            mst_cell #(
                .ID_BITS (ID_BITS),
                .W       (W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .init_en  (init_en),
                .shift_en (shift_en),
                .init_id  (ID_BITS'(gi + 2)),
                .d_id     (d_id),
                .d_cost   (d_cost),
                .d_near   (d_near),
                .d_in     (d_in),
                .q_id     (c_id[gi]),
                .q_cost   (c_cost[gi]),
                .q_near   (c_near[gi]),
                .q_in     (c_in[gi])
            );
        end
    endgenerate

    // prime reads the head's weight, run reads one ahead of the head
    assign rd_b = (state_reg == mst_pkg::ST_PRIME) ? c_id[0] : c_id[NEXT];

    mst_store #(
        .MAX_NODES (MAX_NODES),
        .W         (W),
        .ID_BITS   (ID_BITS)
    ) u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr_start (clr_start),
        .busy      (st_busy),
        .wr_en     (accept && s_tuser == mst_pkg::OP_WRITE && wr_ok),
        .wr_a      (ID_BITS'(in_a)),
        .wr_b      (ID_BITS'(in_b)),
        .wr_data   (in_w),
        .rd_a      (pick_reg),
        .rd_b      (rd_b),
        .rd_data   (rd_data)
    );

    // end-of-pass outcome, including the head cell of this cycle
    logic               pass_end;
    logic [W-1:0]       fin_val;
    logic [ID_BITS-1:0] fin_id, fin_near;

    assign pass_end = (state_reg == mst_pkg::ST_RUN) && (cnt_reg == CNT_B'(NC - 1));
    assign fin_val  = h_cand ? h_cost : best_val_reg;
    assign fin_id   = h_cand ? c_id[0] : best_id_reg;
    assign fin_near = h_cand ? h_near : best_near_reg;
    assign out_load = (state_reg == mst_pkg::ST_EMIT) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        clr_start  = 1'b0;
        init_en    = 1'b0;
        shift_en   = 1'b0;
        unique case (state_reg)
            mst_pkg::ST_CLEAR:
            begin
                if (!st_busy)
                begin
                    state_next = mst_pkg::ST_IDLE;
                end
            end
            mst_pkg::ST_IDLE:
            begin
                // s_tready is high here, so s_tvalid alone marks a word
                s_tready = 1'b1;
                if (s_tvalid && s_tuser == mst_pkg::OP_CLEAR)
                begin
                    clr_start  = 1'b1;
                    state_next = mst_pkg::ST_CLEAR;
                end
                else if (s_tvalid && s_tuser == mst_pkg::OP_RUN)
                begin
                    init_en    = 1'b1;
                    state_next = (n_eff == ID_BITS'(1)) ? mst_pkg::ST_EMIT
                                                        : mst_pkg::ST_PRIME;
                end
            end
            mst_pkg::ST_PRIME:
            begin
                state_next = mst_pkg::ST_RUN;
            end
            mst_pkg::ST_RUN:
            begin
                shift_en = 1'b1;
                if (pass_end)
                begin
                    state_next = mst_pkg::ST_EMIT;
                end
            end
            mst_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    state_next = pend_last_reg ? mst_pkg::ST_IDLE : mst_pkg::ST_PRIME;
                end
            end
            default:
            begin
                state_next = mst_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mst_pkg::ST_CLEAR;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            steps_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
            if (state_reg == mst_pkg::ST_PRIME)
            begin
                cnt_reg <= '0;
            end
            else if (shift_en)
            begin
                cnt_reg <= cnt_reg + CNT_B'(1);
            end
            if (init_en)
            begin
                steps_reg <= '0;
            end
            else if (pass_end)
            begin
                steps_reg <= steps_reg + ID_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (init_en)
        begin
            pick_reg        <= ID_BITS'(1);
            total_reg       <= '0;
            pend_from_reg   <= '0;
            pend_to_reg     <= '0;
            pend_w_reg      <= '0;
            pend_status_reg <= mst_pkg::STATUS_SINGLE;
            pend_last_reg   <= 1'b1;
        end
        if (state_reg == mst_pkg::ST_PRIME)
        begin
            best_val_reg <= '1;
            best_id_reg  <= '0;
        end
        else if (shift_en && h_cand)
        begin
            best_val_reg  <= h_cost;
            best_id_reg   <= c_id[0];
            best_near_reg <= h_near;
        end
        if (pass_end)
        begin
            if (fin_id == '0)
            begin
                pend_from_reg   <= '0;
                pend_to_reg     <= '0;
                pend_w_reg      <= '0;
                pend_status_reg <= mst_pkg::STATUS_DISC;
                pend_last_reg   <= 1'b1;
            end
            else
            begin
                pend_from_reg   <= NF'(fin_near);
                pend_to_reg     <= NF'(fin_id);
                pend_w_reg      <= fin_val;
                pend_status_reg <= mst_pkg::STATUS_EDGE;
                pend_last_reg   <= (steps_reg + ID_BITS'(2) == n_eff);
                total_reg       <= total_reg + TB'(fin_val);
                pick_reg        <= fin_id;
            end
        end
        if (out_load)
        begin
            m_data_reg <= OUT_W'({total_reg, pend_w_reg, pend_to_reg, pend_from_reg});
            m_user_reg <= pend_status_reg;
            m_last_reg <= pend_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;
endmodule
`default_nettype wire

/* hdl/mst_checker.sv */
// ----------------------------------------------------------------------------
// Dense MST port checker
// Port-level checks on the result stream, bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "minimum_spanning_tree_dense_core_defines.svh"
module mst_checker #(
    parameter int OUT_W = 56
) (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [OUT_W-1:0]                m_tdata,
    input wire logic [mst_pkg::STATUS_BITS-1:0] m_tuser,
    input wire logic                            m_tlast
);
    `MST_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid, "result word dropped")
    `MST_ASSERT(a_single_last, clk, rst_n, m_tvalid && m_tuser == mst_pkg::STATUS_SINGLE |-> m_tlast, "single node not last")
    `MST_ASSERT(a_disc_last, clk, rst_n, m_tvalid && m_tuser == mst_pkg::STATUS_DISC |-> m_tlast, "disconnect not last")
    `MST_ASSERT(a_edge_to, clk, rst_n, m_tvalid && m_tuser == mst_pkg::STATUS_EDGE |-> m_tdata[13:7] != 7'd0, "edge without node")
endmodule

bind minimum_spanning_tree_dense_core mst_checker #(
    .OUT_W (OUT_W)
) u_mst_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
